// File: rtl/core/ezr_pkg.sv
// shared constants, types and tables for the euler zyx rotation matrix unit
`default_nettype none
package ezr_pkg;
	localparam int CordicIterations = 16;
	localparam int OutputFracBits = 16;
	localparam int AtanCount = 30;
	localparam int PhaseW = 32;
	localparam int CordW = 34;
	localparam logic [24:0] DegTurn = 25'd23592960;
	localparam logic [45:0] RadToPhase = 46'd44798133900177;
	localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
	localparam logic [0:0] UnitRadians = 1'b0;
	localparam logic [0:0] UnitDegrees = 1'b1;
	localparam logic [1:0] RegAngleUnit = 2'd0;

	typedef struct packed {
		logic signed [CordW-1:0] s;
		logic signed [CordW-1:0] c;
	} sincos_t;

	function automatic logic [PhaseW-1:0] atan_turn(input int i);
		logic [PhaseW-1:0] v;
		begin
			case (i)
				0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
				3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
				6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
				9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
				12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41722;
				15: v = 32'd20861;     16: v = 32'd10430;     17: v = 32'd5215;
				18: v = 32'd2608;      19: v = 32'd1304;      20: v = 32'd652;
				21: v = 32'd326;       22: v = 32'd163;       23: v = 32'd81;
				24: v = 32'd41;        25: v = 32'd20;        26: v = 32'd10;
				27: v = 32'd5;         28: v = 32'd3;         29: v = 32'd1;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// signed q3.30 product, rounded half up
	function automatic logic signed [CordW-1:0] mul_q30(input logic signed [CordW-1:0] a,
			input logic signed [CordW-1:0] b);
		logic signed [2*CordW-1:0] p;
		begin
			p = a * b + (68'sd1 <<< 29);
			return CordW'(p >>> 30);
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/ezr_phase.sv
// angle to phase reduction, four stages, one angle
`default_nettype none
module ezr_phase (
	input  wire                        clk,
	input  wire                        en,
	input  wire                        unit_deg,
	input  wire signed [31:0]          angle,
	output logic [ezr_pkg::PhaseW-1:0] phase
);
	// a full turn in degrees is 45 * 2^19, so the phase is
	// floor((rem * 2^13 + 22) / 45), split as q45 * 2^13 + frac(rem mod 45)
	localparam logic [25:0] Recip45 = 26'd47721859;    // ceil(2^31 / 45)
	localparam logic [19:0] Recip45Frac = 20'd745655;  // ceil(2^25 / 45)

	logic signed [32:0] a_ext;
	logic signed [63:0] qmul;
	logic signed [55:0] rad_hi, rad_lo;
	logic unit_s1, unit_s2, unit_s3;
	logic signed [32:0] a_s1;
	logic signed [8:0] q_s1;
	logic signed [55:0] rad_hi_s1, rad_lo_s1;
	logic signed [33:0] rem_c;
	logic [63:0] rad_sum;
	logic [31:0] rad_s2, rad_s3;
	logic [24:0] rem_s2, rem_s3;
	logic [50:0] q45_prod;
	logic [18:0] q45_s3;
	logic [5:0] r45;
	logic [18:0] frac_num;
	logic [38:0] frac_prod;

	// stage 1: floor(a/turn) estimate, radian product in two halves
	assign a_ext = 33'(angle);
	// a * floor(2^40/turn) >> 40, off by at most one
	assign qmul = 64'(a_ext) * 64'(33'sd46603);
	assign rad_hi = 56'(a_ext) * 56'($signed({1'b0, ezr_pkg::RadToPhase[45:23]}));
	assign rad_lo = 56'(a_ext) * 56'($signed({1'b0, ezr_pkg::RadToPhase[22:0]}));

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s1   <= unit_deg;
			a_s1      <= a_ext;
			q_s1      <= 9'(qmul >>> 40);
			rad_hi_s1 <= rad_hi;
			rad_lo_s1 <= rad_lo;
		end
	end

	// stage 2: remainder in [0, turn), radian phase rounded
	always_comb begin
		rem_c = 34'(a_s1) - 34'(q_s1) * 34'(ezr_pkg::DegTurn);
		if (rem_c < 0) rem_c = rem_c + 34'(ezr_pkg::DegTurn);
		if (rem_c >= 34'(ezr_pkg::DegTurn)) rem_c = rem_c - 34'(ezr_pkg::DegTurn);
	end

	assign rad_sum = (64'(rad_hi_s1) << 23) + 64'(rad_lo_s1) + 64'h8000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s2 <= unit_s1;
			rad_s2  <= rad_sum[63:32];
			rem_s2  <= 25'(rem_c);
		end
	end

	// stage 3: quotient by 45
	assign q45_prod = 51'(rem_s2) * 51'(Recip45);

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s3 <= unit_s2;
			rad_s3  <= rad_s2;
			rem_s3  <= rem_s2;
			q45_s3  <= q45_prod[49:31];
		end
	end

	// stage 4: fraction from the remainder by 45, then select
	assign r45 = 6'(rem_s3 - 25'(q45_s3) * 25'd45);
	assign frac_num = {r45, 13'd0} + 19'd22;
	assign frac_prod = 39'(frac_num) * 39'(Recip45Frac);

	always_ff @(posedge clk) begin
		if (en) phase <= (unit_s3 == ezr_pkg::UnitDegrees) ?
			{q45_s3, frac_prod[37:25]} : rad_s3;
	end
endmodule
`default_nettype wire

// File: rtl/core/ezr_cordic.sv
// unrolled rotation-mode cordic, one register stage per step
`default_nettype none
module ezr_cordic #(
	parameter int Iterations = ezr_pkg::CordicIterations
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire [ezr_pkg::PhaseW-1:0]  phase,
	output ezr_pkg::sincos_t           sc
);
	localparam int N = (Iterations < ezr_pkg::AtanCount) ? Iterations : ezr_pkg::AtanCount;
	logic signed [ezr_pkg::CordW-1:0] x_s [0:N];
	logic signed [ezr_pkg::CordW-1:0] y_s [0:N];
	logic signed [ezr_pkg::PhaseW:0]  z_s [0:N];
	logic flip_s [0:N];
	logic signed [ezr_pkg::PhaseW:0] z0;
	logic f0;

	always_comb begin
		z0 = $signed({phase[31], phase});
		f0 = 1'b0;
		if (z0 > 33'sh40000000) begin
			z0 = z0 - 33'sh80000000; f0 = 1'b1;
		end else if (z0 < -33'sh40000000) begin
			z0 = z0 + 33'sh80000000; f0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= ezr_pkg::GainQ30;
			y_s[0] <= '0;
			z_s[0] <= z0;
			flip_s[0] <= f0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [ezr_pkg::PhaseW:0] at;
		assign at = $signed({1'b0, ezr_pkg::atan_turn(i)});
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ezr_pkg::PhaseW]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	assign sc.c = flip_s[N] ? -x_s[N] : x_s[N];
	assign sc.s = flip_s[N] ? -y_s[N] : y_s[N];
endmodule
`default_nettype wire

// File: rtl/core/ezr_matrix.sv
// product pipeline forming the nine matrix elements
`default_nettype none
module ezr_matrix #(
	parameter int FracBits = ezr_pkg::OutputFracBits
) (
	input  wire                    clk,
	input  wire                    en,
	input  ezr_pkg::sincos_t       r,
	input  ezr_pkg::sincos_t       p,
	input  ezr_pkg::sincos_t       y,
	output logic [9*(FracBits+2)-1:0] m
);
	localparam int W = ezr_pkg::CordW;
	localparam int OW = FracBits + 2;
	typedef logic signed [W-1:0] q_t;
	q_t cysp_s1, sysp_s1, cycp_s1, sycp_s1, sycr_s1, sysr_s1, cycr_s1, cysr_s1;
	q_t cpsr_s1, cpcr_s1, nsp_s1, sr_s1, cr_s1;
	q_t e_s2 [0:8];

	function automatic logic [OW-1:0] fin(input q_t v);
		logic signed [W:0] t;
		begin
			t = (W+1)'(v);
			if (30 - FracBits > 0) t = t + ((W+1)'(1) <<< (29 - FracBits));
			t = t >>> (30 - FracBits);
			if (t > ((W+1)'(1) <<< FracBits)) t = (W+1)'(1) <<< FracBits;
			if (t < -((W+1)'(1) <<< FracBits)) t = -((W+1)'(1) <<< FracBits);
			return OW'(t);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s1 <= ezr_pkg::mul_q30(y.c, p.s);
			sysp_s1 <= ezr_pkg::mul_q30(y.s, p.s);
			cycp_s1 <= ezr_pkg::mul_q30(y.c, p.c);
			sycp_s1 <= ezr_pkg::mul_q30(y.s, p.c);
			sycr_s1 <= ezr_pkg::mul_q30(y.s, r.c);
			sysr_s1 <= ezr_pkg::mul_q30(y.s, r.s);
			cycr_s1 <= ezr_pkg::mul_q30(y.c, r.c);
			cysr_s1 <= ezr_pkg::mul_q30(y.c, r.s);
			cpsr_s1 <= ezr_pkg::mul_q30(p.c, r.s);
			cpcr_s1 <= ezr_pkg::mul_q30(p.c, r.c);
			nsp_s1  <= -p.s;
			sr_s1   <= r.s;
			cr_s1   <= r.c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2[0] <= cycp_s1;
			e_s2[1] <= ezr_pkg::mul_q30(cysp_s1, sr_s1) - sycr_s1;
			e_s2[2] <= ezr_pkg::mul_q30(cysp_s1, cr_s1) + sysr_s1;
			e_s2[3] <= sycp_s1;
			e_s2[4] <= ezr_pkg::mul_q30(sysp_s1, sr_s1) + cycr_s1;
			e_s2[5] <= ezr_pkg::mul_q30(sysp_s1, cr_s1) - cysr_s1;
			e_s2[6] <= nsp_s1;
			e_s2[7] <= cpsr_s1;
			e_s2[8] <= cpcr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) m[k*OW +: OW] <= fin(e_s2[k]);
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/euler_zyx_to_rotation_matrix_unit.sv
// top level: euler zyx angles to rotation matrix, stream in and out
`default_nettype none
// Takes one beat of roll, pitch and yaw (signed q16.16, radians or degrees
// per the angle_unit register at address 0) per cycle and returns one beat of
// the nine elements of rz*ry*rx in signed q1.16, saturated to plus or minus
// one. Each item passes through four phase reduction stages, the cordic input
// stage and one cordic stage per step, and three product stages. Throughput is
// one beat per cycle; the whole pipeline advances while the output register is
// empty or being taken, so a stall on the output side freezes it without loss.
module euler_zyx_to_rotation_matrix_unit #(
	parameter int CORDIC_ITERATIONS = ezr_pkg::CordicIterations,
	parameter int OUTPUT_FRAC_BITS  = ezr_pkg::OutputFracBits
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [95:0]  s_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [9*(OUTPUT_FRAC_BITS+2)+((8-(9*(OUTPUT_FRAC_BITS+2))%8)%8)-1:0] m_tdata,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, then zero fill
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [1:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int OW = 9 * (OUTPUT_FRAC_BITS + 2);
	localparam int PadW = (8 - OW % 8) % 8;
	localparam int NSteps = (CORDIC_ITERATIONS < ezr_pkg::AtanCount) ?
		CORDIC_ITERATIONS : ezr_pkg::AtanCount;
	localparam int Lat = 4 + NSteps + 1 + 3;

	logic unit_q;
	logic en;
	logic [Lat-1:0] vld_q;
	logic [ezr_pkg::PhaseW-1:0] ph_r, ph_p, ph_y;
	ezr_pkg::sincos_t sc_r, sc_p, sc_y;
	logic [OW-1:0] m;

	// config register, always ready
	assign pready = 1'b1;
	assign prdata = {31'd0, unit_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= ezr_pkg::UnitRadians;
		end else if (psel && penable && pwrite && paddr == ezr_pkg::RegAngleUnit) begin
			unit_q <= pwdata[0];
		end
	end

	// the pipeline moves unless the last stage holds a beat that is not taken
	assign en = !(m_tvalid && !m_tready);
	assign s_tready = en;
	assign m_tvalid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_tvalid};
		end
	end

	ezr_phase u_ph_r (.clk, .en, .unit_deg(unit_q),
		.angle($signed(s_tdata[31:0])), .phase(ph_r));
	ezr_phase u_ph_p (.clk, .en, .unit_deg(unit_q),
		.angle($signed(s_tdata[63:32])), .phase(ph_p));
	ezr_phase u_ph_y (.clk, .en, .unit_deg(unit_q),
		.angle($signed(s_tdata[95:64])), .phase(ph_y));

	ezr_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cr (.clk, .en, .phase(ph_r), .sc(sc_r));
	ezr_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cp (.clk, .en, .phase(ph_p), .sc(sc_p));
	ezr_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cy (.clk, .en, .phase(ph_y), .sc(sc_y));

	ezr_matrix #(.FracBits(OUTPUT_FRAC_BITS)) u_mat (.clk, .en,
		.r(sc_r), .p(sc_p), .y(sc_y), .m(m));

	if (PadW > 0) begin : g_pad
		assign m_tdata = {{PadW{1'b0}}, m};
	end else begin : g_nopad
		assign m_tdata = m;
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted beat lost at entry");
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(unit_q))
		else $error("angle unit changed without write");
`endif
endmodule
`default_nettype wire

// File: sim/tb_euler_zyx_to_rotation_matrix_unit.sv
// testbench for the euler zyx rotation matrix unit: predicted matrices checked beat by beat
`timescale 1ns / 100ps
module tb_euler_zyx_to_rotation_matrix_unit;
	localparam int ElemW = ezr_pkg::OutputFracBits + 2;
	localparam int OutW = 9 * ElemW + ((8 - (9 * ElemW) % 8) % 8);
	localparam int Latency = 4 + (ezr_pkg::CordicIterations + 1) + 3;
	localparam int WatchLimit = 2000;

	logic clk, arst_n;
	logic s_tvalid, m_tready;
	logic [95:0] s_tdata;
	logic s_tready, m_tvalid;
	logic [OutW-1:0] m_tdata;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	euler_zyx_to_rotation_matrix_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// expected matrices, oldest first, each packed like m_tdata
	logic [OutW-1:0] matrix_q[$];
	logic unit_deg;
	int errors = 0;
	int idle_cycles = 0;
	bit hold_sink = 0;
	bit sink_random = 1;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// atan table for the predictor, turn units
	function automatic longint atan_of(int i);
		longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
		return t[i];
	endfunction

	function automatic longint prod_rnd(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// angle to 32-bit phase, one turn = 2^32
	function automatic logic [31:0] angle_phase(logic [31:0] raw, logic deg);
		longint a, r;
		logic [127:0] w;
		a = longint'($signed(raw));
		if (deg) begin
			r = a % 64'sd23592960;
			if (r < 0) r += 64'sd23592960;
			w = ((128'(r) << 32) + 128'd11796480) / 128'd23592960;
			return w[31:0];
		end
		w = 128'($signed(a)) * 128'd44798133900177 + 128'h80000000;
		return w[63:32];
	endfunction

	task automatic sine_cosine(input logic [31:0] raw, input logic deg,
			output longint s, output longint c);
		logic [31:0] ph;
		longint z, x, y, dx, dy;
		bit flip;
		ph = angle_phase(raw, deg);
		z = longint'($signed(ph));
		flip = 0;
		x = 652032874;
		y = 0;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000; flip = 1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000; flip = 1;
		end
		for (int i = 0; i < ezr_pkg::CordicIterations && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_of(i);
			end else begin
				x += dx; y -= dy; z += atan_of(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		c = x;
	endtask

	function automatic logic [ElemW-1:0] to_q1(longint v);
		longint one, r;
		one = 64'sd1 <<< ezr_pkg::OutputFracBits;
		r = (v + (64'sd1 <<< (29 - ezr_pkg::OutputFracBits))) >>>
			(30 - ezr_pkg::OutputFracBits);
		if (r > one) r = one;
		if (r < -one) r = -one;
		return r[ElemW-1:0];
	endfunction

	task automatic predict_matrix(input logic [95:0] ang, output logic [OutW-1:0] m);
		longint sr, cr, sp, cp, sy, cy, cysp, sysp;
		logic [ElemW-1:0] e[9];
		sine_cosine(ang[31:0], unit_deg, sr, cr);
		sine_cosine(ang[63:32], unit_deg, sp, cp);
		sine_cosine(ang[95:64], unit_deg, sy, cy);
		cysp = prod_rnd(cy, sp);
		sysp = prod_rnd(sy, sp);
		e[0] = to_q1(prod_rnd(cy, cp));
		e[1] = to_q1(prod_rnd(cysp, sr) - prod_rnd(sy, cr));
		e[2] = to_q1(prod_rnd(cysp, cr) + prod_rnd(sy, sr));
		e[3] = to_q1(prod_rnd(sy, cp));
		e[4] = to_q1(prod_rnd(sysp, sr) + prod_rnd(cy, cr));
		e[5] = to_q1(prod_rnd(sysp, cr) - prod_rnd(cy, sr));
		e[6] = to_q1(-sp);
		e[7] = to_q1(prod_rnd(cp, sr));
		e[8] = to_q1(prod_rnd(cp, cr));
		m = '0;
		for (int k = 0; k < 9; k++) m[k*ElemW +: ElemW] = e[k];
	endtask

	// one angle triple onto the input side, then a random gap if gaps is set
	task automatic send_angles(input logic [31:0] roll, input logic [31:0] pitch,
			input logic [31:0] yaw, input bit gaps = 1);
		logic [OutW-1:0] m;
		int gap;
		predict_matrix({yaw, pitch, roll}, m);
		s_tdata <= {yaw, pitch, roll};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		matrix_q.push_back(m);
		gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (matrix_q.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	task automatic write_unit(input logic deg);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 2'(ezr_pkg::RegAngleUnit << 2);
		pwdata <= {31'($urandom_range(0, 32'h7fff_ffff)), deg};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		unit_deg = deg;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
			2: return 32'($signed($urandom_range(0, 32'h0007_0000)) - 32'sh0003_8000);
			3: return 32'($signed(24'($urandom_range(0, 720))) - 32'sd360) << 16;
			default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	// extremes, quarter and half turns in both units
	task automatic test_directed();
		logic [31:0] vals[12] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1,
			32'h00b40000, 32'hff4c0000, 32'h005a0000, 32'h00032440, 32'h0001921f,
			32'h01680000, 32'hfffcdbc0};
		write_unit(ezr_pkg::UnitRadians);
		for (int i = 0; i < 12; i++) send_angles(vals[i], vals[(i + 5) % 12], vals[(i + 7) % 12]);
		drain();
		write_unit(ezr_pkg::UnitDegrees);
		for (int i = 0; i < 12; i++) send_angles(vals[(i + 3) % 12], vals[i], vals[(i + 9) % 12]);
		drain();
	endtask

	task automatic test_random(input logic deg, input int n);
		write_unit(deg);
		for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
		drain();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		write_unit(ezr_pkg::UnitDegrees);
		hold_sink = 1;
		fork
			begin
				repeat (150) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 60; i++) send_angles(rand_angle(), rand_angle(), rand_angle(), 0);
		join
		drain();
	endtask

	// result side: random stalls, sampled at the clock edge
	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 0;
				@(posedge clk);
			end else begin
				stall = (sink_random && $urandom_range(0, 2) != 0) ? $urandom_range(0, 19) : 0;
				if (stall > 0) begin
					m_tready <= 0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1;
				do @(posedge clk); while (!m_tvalid && !hold_sink);
			end
		end
	end

	// checker: each result beat against the oldest expected matrix
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (matrix_q.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				errors++;
			end else begin
				logic [OutW-1:0] want;
				want = matrix_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_tdata[k*ElemW +: ElemW] !== want[k*ElemW +: ElemW]) begin
						$error("m%0d%0d expected %0d actual %0d", k / 3, k % 3,
							$signed(want[k*ElemW +: ElemW]), $signed(m_tdata[k*ElemW +: ElemW]));
						errors++;
					end
				if (m_tdata[OutW-1:9*ElemW] !== '0) begin
					$error("fill expected 0 actual %h", m_tdata[OutW-1:9*ElemW]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		unit_deg = ezr_pkg::UnitRadians;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(ezr_pkg::UnitRadians, 220);
		test_random(ezr_pkg::UnitDegrees, 220);
		test_backpressure();
		sink_random = 0;
		test_random(ezr_pkg::UnitRadians, 100);
		sink_random = 1;
		if (errors == 0 && matrix_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/core/ezr_pkg.sv
rtl/core/ezr_phase.sv
rtl/core/ezr_cordic.sv
rtl/core/ezr_matrix.sv
rtl/core/euler_zyx_to_rotation_matrix_unit.sv
sim/tb_euler_zyx_to_rotation_matrix_unit.sv
